// File: hdl/led_fx_pkg.sv
package led_fx_pkg;

   localparam int LED_COUNT_DEF = 16;

   localparam int CMD_W      = 2;
   localparam int DUR_W      = 16;
   localparam int PIX_IDX_W  = 6;
   localparam int CHAN_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int STYLE_W    = 3;
   localparam int PCT_W      = 7;
   localparam int PROD_W     = 15;
   localparam int SPAN_PROD_W = 14;

   localparam logic [DUR_W-1:0]   INTERVAL_RST = 16'd45;
   localparam logic [CHAN_W-1:0]  BLUE_RST     = 8'd40;
   localparam logic [PCT_W-1:0]   USER_BRT_RST = 7'd20;
   localparam logic [PCT_W-1:0]   MOOD_BRT_RST = 7'd100;

   localparam logic [7:0]         PHASE_STEP   = 8'd7;
   localparam logic [10:0]        HAPPY_SPREAD = 11'd21;
   localparam logic [PCT_W-1:0]   CALM_LO      = 7'd24;
   localparam logic [PCT_W-1:0]   CALM_SPAN    = 7'd54;
   localparam logic [PCT_W-1:0]   SLEEPY_LO    = 7'd12;
   localparam logic [PCT_W-1:0]   SLEEPY_SPAN  = 7'd33;
   localparam logic [PCT_W-1:0]   HAPPY_LO     = 7'd28;
   localparam logic [PCT_W-1:0]   HAPPY_SPAN   = 7'd72;
   localparam logic [PCT_W-1:0]   SPARK_PCT    = 7'd24;
   localparam logic [PCT_W-1:0]   COMET_HEAD   = 7'd100;
   localparam logic [PCT_W-1:0]   COMET_NEAR   = 7'd60;
   localparam logic [PCT_W-1:0]   COMET_FAR    = 7'd30;
   localparam logic [PCT_W-1:0]   COMET_BG     = 7'd28;
   localparam logic [PCT_W-1:0]   DIM_RG       = 7'd70;
   localparam logic [PCT_W-1:0]   DIM_B        = 7'd85;
   localparam logic [PCT_W-1:0]   PCT_FULL     = 7'd100;
   localparam logic [CHAN_W-1:0]  CHAN_MAX     = 8'd255;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK   = 2'd0,
      CMD_ACCENT = 2'd1,
      CMD_RENDER = 2'd2
   } cmd_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_STYLE    = 3'd0,
      REG_INTERVAL = 3'd1,
      REG_BOOST    = 3'd2,
      REG_RED      = 3'd3,
      REG_GREEN    = 3'd4,
      REG_BLUE     = 3'd5,
      REG_USER_BRT = 3'd6,
      REG_MOOD_BRT = 3'd7
   } csr_index_type;

   typedef enum logic [STYLE_W-1:0] {
      STYLE_CALM   = 3'd0,
      STYLE_SLEEPY = 3'd1,
      STYLE_HAPPY  = 3'd2,
      STYLE_SPARK  = 3'd3,
      STYLE_COMET  = 3'd4
   } style_type;

   typedef enum logic [1:0] {
      MUL_SCALE,
      MUL_DIM,
      MUL_BOOST
   } mul_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PCT,
      ST_SCALE_MUL,
      ST_SCALE_DIV,
      ST_DIM_MUL,
      ST_DIM_DIV,
      ST_BOOST_MUL,
      ST_BOOST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic        take;
      logic        calc_pct;
      logic        mul;
      logic        div;
      mul_sel_type sel;
      logic        out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic frame_go;
      logic raw;
      logic dim;
      logic last;
      logic out_free;
   } dp_status_type;

   // triangle wave over the 8-bit phase, 0..127
   function automatic logic [PCT_W-1:0] tri_of(input logic [7:0] ph);
      return ph[7] ? ~ph[6:0] : ph[6:0];
   endfunction

   // floor(x / 127) for x below 127 * 72 + 127
   function automatic logic [PCT_W-1:0] div127(input logic [SPAN_PROD_W-1:0] x);
      logic [PCT_W-1:0] q0;
      logic [7:0]       r;
      q0 = x[13:7];
      r  = {1'b0, x[6:0]} + {1'b0, q0};
      return q0 + PCT_W'(r >= 8'd127);
   endfunction

   // floor(x / 100) by reciprocal, exact over the 15-bit range used here
   function automatic logic [8:0] div100(input logic [PROD_W-1:0] x);
      logic [27:0] p;
      p = 28'(x) * 28'd5243;
      return p[27:19];
   endfunction

   // flash frames are those where (phase / 12) mod 3 is zero
   function automatic logic spark_on(input logic [7:0] ph);
      logic [18:0] m;
      logic [7:0]  q;
      logic        on;
      m = 19'(ph) * 19'd171;
      q = m[18:11];
      case (q) inside
         8'd0, 8'd3, 8'd6, 8'd9, 8'd12, 8'd15, 8'd18, 8'd21: on = 1'b1;
         default: on = 1'b0;
      endcase
      return on;
   endfunction

endpackage

// File: hdl/led_fx_if.sv
interface led_fx_req_if;
   import led_fx_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     command;
   logic [DUR_W-1:0]     accent_duration_ms;
   modport source (output valid, command, accent_duration_ms, input ready);
   modport sink (input valid, command, accent_duration_ms, output ready);
endinterface

interface led_fx_rsp_if;
   import led_fx_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [PIX_IDX_W-1:0] pixel_index;
   logic [CHAN_W-1:0]    red;
   logic [CHAN_W-1:0]    green;
   logic [CHAN_W-1:0]    blue;
   logic [CHAN_W-1:0]    strip_level;
   logic                 last_pixel;
   modport source (output valid, pixel_index, red, green, blue, strip_level, last_pixel,
                   input ready);
   modport sink (input valid, pixel_index, red, green, blue, strip_level, last_pixel,
                 output ready);
endinterface

interface led_fx_csr_if;
   import led_fx_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] wdata;
   modport source (output valid, reg_index, wdata, input ready);
   modport sink (input valid, reg_index, wdata, output ready);
endinterface

// File: hdl/led_fx_ctrl.sv
module led_fx_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  led_fx_pkg::dp_status_type  status,
   output led_fx_pkg::dp_cmd_type     cmd
);
   import led_fx_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.sel  = MUL_SCALE;
      case (state_ff)
         ST_IDLE: begin
            cmd.take = 1'b1;
            if (status.frame_go) state_in = ST_PCT;
         end
         ST_PCT: begin
            cmd.calc_pct = 1'b1;
            // flash pixels skip scaling and accent
            state_in = status.raw ? ST_OUT : ST_SCALE_MUL;
         end
         ST_SCALE_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SCALE_DIV;
         end
         ST_SCALE_DIV: begin
            cmd.div  = 1'b1;
            state_in = status.dim ? ST_DIM_MUL : ST_BOOST_MUL;
         end
         ST_DIM_MUL: begin
            cmd.mul  = 1'b1;
            cmd.sel  = MUL_DIM;
            state_in = ST_DIM_DIV;
         end
         ST_DIM_DIV: begin
            cmd.div  = 1'b1;
            cmd.sel  = MUL_DIM;
            state_in = ST_BOOST_MUL;
         end
         ST_BOOST_MUL: begin
            cmd.mul  = 1'b1;
            cmd.sel  = MUL_BOOST;
            state_in = ST_BOOST_DIV;
         end
         ST_BOOST_DIV: begin
            cmd.div  = 1'b1;
            cmd.sel  = MUL_BOOST;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = status.last ? ST_IDLE : ST_PCT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: hdl/led_fx_dp.sv
module led_fx_dp #(
   parameter int LED_COUNT = led_fx_pkg::LED_COUNT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   led_fx_req_if.sink                 req_ch,
   led_fx_rsp_if.source               rsp_ch,
   led_fx_csr_if.sink                 csr_ch,
   input  led_fx_pkg::dp_cmd_type     cmd,
   output led_fx_pkg::dp_status_type  status
);
   import led_fx_pkg::*;

   localparam int PIX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam logic [PIX_W-1:0] PIX_LAST = PIX_W'(LED_COUNT - 1);

   // configuration
   logic [STYLE_W-1:0] style_ff;
   logic [DUR_W-1:0]   interval_ff;
   logic [PCT_W-1:0]   boost_ff;
   logic [CHAN_W-1:0]  base_ff [3];
   logic [PCT_W-1:0]   user_brt_ff;
   logic [PCT_W-1:0]   mood_brt_ff;

   // animation state
   logic [DUR_W-1:0]   elapsed_ff, elapsed_in;
   logic [PIX_W-1:0]   offset_ff, offset_in;
   logic [7:0]         phase_ff, phase_in;
   logic [DUR_W-1:0]   accent_ff, accent_in;

   // per-pixel datapath
   logic [PIX_W-1:0]   pixel_ff;
   logic [PCT_W-1:0]   pct_ff, pct_in;
   logic               dim_ff, dim_in;
   logic               raw_in;
   logic [CHAN_W-1:0]  chan_ff [3];
   logic [PROD_W-1:0]  prod_ff [3];
   logic [PCT_W-1:0]   factor [3];
   logic [8:0]         quot [3];
   logic [9:0]         bsum [3];
   logic [CHAN_W-1:0]  div_res [3];
   logic [PCT_W-1:0]   amt;

   // strip level
   logic [PCT_W-1:0]   ub, mb, brt_min;
   logic [PROD_W-1:0]  lvl_prod_ff;
   logic [8:0]         lvl_quot;
   logic [CHAN_W-1:0]  level_ff;

   // output register
   logic                 rsp_valid_ff;
   logic [PIX_IDX_W-1:0] rsp_pix_ff;
   logic [CHAN_W-1:0]    rsp_chan_ff [3];
   logic [CHAN_W-1:0]    rsp_level_ff;
   logic                 rsp_last_ff;

   logic               accept;
   logic [DUR_W-1:0]   elapsed_inc;
   logic               fire;
   logic               frame_go;
   logic               last;

   logic [5:0]         i6, off6, pix_dist;
   logic [10:0]        spread;
   logic [7:0]         happy_ph;
   logic [PCT_W-1:0]   tri_val, span, lo;
   logic [SPAN_PROD_W-1:0] span_prod;

   assign accept = req_ch.valid && cmd.take;
   assign req_ch.ready = cmd.take;
   assign csr_ch.ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         style_ff    <= '0;
         interval_ff <= INTERVAL_RST;
         boost_ff    <= '0;
         base_ff[0]  <= '0;
         base_ff[1]  <= '0;
         base_ff[2]  <= BLUE_RST;
         user_brt_ff <= USER_BRT_RST;
         mood_brt_ff <= MOOD_BRT_RST;
      end else if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.reg_index))
            REG_STYLE:    style_ff    <= csr_ch.wdata[STYLE_W-1:0];
            REG_INTERVAL: interval_ff <= csr_ch.wdata[DUR_W-1:0];
            REG_BOOST:    boost_ff    <= csr_ch.wdata[PCT_W-1:0];
            REG_RED:      base_ff[0]  <= csr_ch.wdata[CHAN_W-1:0];
            REG_GREEN:    base_ff[1]  <= csr_ch.wdata[CHAN_W-1:0];
            REG_BLUE:     base_ff[2]  <= csr_ch.wdata[CHAN_W-1:0];
            REG_USER_BRT: user_brt_ff <= csr_ch.wdata[PCT_W-1:0];
            REG_MOOD_BRT: mood_brt_ff <= csr_ch.wdata[PCT_W-1:0];
            default: ;
         endcase
      end
   end

   // command handling
   always_comb begin
      elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;
      fire        = elapsed_inc >= interval_ff;
      elapsed_in  = elapsed_ff;
      offset_in   = offset_ff;
      phase_in    = phase_ff;
      accent_in   = accent_ff;
      frame_go    = 1'b0;
      if (accept) begin
         case (cmd_code_type'(req_ch.command))
            CMD_TICK: begin
               if (accent_ff != '0) accent_in = accent_ff - 1'b1;
               if (fire) begin
                  elapsed_in = '0;
                  offset_in  = (offset_ff == PIX_LAST) ? '0 : offset_ff + 1'b1;
                  phase_in   = phase_ff + PHASE_STEP;
                  frame_go   = 1'b1;
               end else begin
                  elapsed_in = elapsed_inc;
               end
            end
            CMD_ACCENT: accent_in = req_ch.accent_duration_ms;
            CMD_RENDER: frame_go = 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         offset_ff  <= '0;
         phase_ff   <= '0;
         accent_ff  <= '0;
      end else begin
         elapsed_ff <= elapsed_in;
         offset_ff  <= offset_in;
         phase_ff   <= phase_in;
         accent_ff  <= accent_in;
      end
   end

   // per-pixel percent from the style
   always_comb begin
      i6       = 6'(pixel_ff);
      off6     = 6'(offset_ff);
      spread   = 11'(i6) * HAPPY_SPREAD;
      happy_ph = phase_ff + spread[7:0];
      pix_dist = (i6 >= off6) ? i6 - off6 : off6 - i6;
      tri_val  = tri_of(phase_ff);
      span     = CALM_SPAN;
      lo       = CALM_LO;
      raw_in   = 1'b0;
      dim_in   = 1'b0;
      case (style_ff)
         STYLE_CALM: begin
            span = CALM_SPAN;
            lo   = CALM_LO;
         end
         STYLE_SLEEPY: begin
            span   = SLEEPY_SPAN;
            lo     = SLEEPY_LO;
            dim_in = (i6[0] == off6[1]);
         end
         STYLE_HAPPY: begin
            tri_val = tri_of(happy_ph);
            span    = HAPPY_SPAN;
            lo      = HAPPY_LO;
         end
         default: ;
      endcase
      span_prod = SPAN_PROD_W'(tri_val) * SPAN_PROD_W'(span);
      case (style_ff)
         STYLE_CALM, STYLE_SLEEPY, STYLE_HAPPY: pct_in = lo + div127(span_prod);
         STYLE_SPARK: begin
            pct_in = SPARK_PCT;
            raw_in = spark_on(phase_ff) && (i6[0] == off6[0]);
         end
         default: begin
            // comet head and tail, never below the background glow
            case (pix_dist)
               6'd0:    pct_in = COMET_HEAD;
               6'd1:    pct_in = COMET_NEAR;
               6'd2:    pct_in = COMET_FAR;
               default: pct_in = COMET_BG;
            endcase
         end
      endcase
   end

   assign amt = (accent_ff != '0) ? boost_ff : '0;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         case (cmd.sel)
            MUL_SCALE: factor[c] = pct_ff;
            MUL_DIM:   factor[c] = (c == 2) ? DIM_B : DIM_RG;
            default:   factor[c] = amt;
         endcase
         quot[c] = div100(prod_ff[c]);
         bsum[c] = 10'(chan_ff[c]) + 10'(quot[c]);
         if (cmd.sel == MUL_BOOST) begin
            div_res[c] = (bsum[c] > 10'(CHAN_MAX)) ? CHAN_MAX : bsum[c][7:0];
         end else begin
            div_res[c] = quot[c][7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc_pct) begin
         pct_ff <= pct_in;
         dim_ff <= dim_in;
      end
      for (int c = 0; c < 3; c++) begin
         if (cmd.calc_pct) begin
            chan_ff[c] <= raw_in ? CHAN_MAX : base_ff[c];
         end else if (cmd.div) begin
            chan_ff[c] <= div_res[c];
         end
         if (cmd.mul) prod_ff[c] <= PROD_W'(chan_ff[c]) * PROD_W'(factor[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_ff <= '0;
      end else if (accept) begin
         pixel_ff <= '0;
      end else if (cmd.out_load && !last) begin
         pixel_ff <= pixel_ff + 1'b1;
      end
   end

   assign last = (pixel_ff == PIX_LAST);

   // strip level follows the brightness registers
   always_comb begin
      ub      = (user_brt_ff > PCT_FULL) ? PCT_FULL : user_brt_ff;
      mb      = (mood_brt_ff > PCT_FULL) ? PCT_FULL : mood_brt_ff;
      brt_min = (ub < mb) ? ub : mb;
   end

   assign lvl_quot = div100(lvl_prod_ff);

   always_ff @(posedge clock) begin
      lvl_prod_ff <= PROD_W'(brt_min) * PROD_W'(CHAN_MAX);
      level_ff    <= lvl_quot[7:0];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_pix_ff   <= PIX_IDX_W'(pixel_ff);
         rsp_chan_ff  <= chan_ff;
         rsp_level_ff <= level_ff;
         rsp_last_ff  <= last;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.pixel_index = rsp_pix_ff;
   assign rsp_ch.red         = rsp_chan_ff[0];
   assign rsp_ch.green       = rsp_chan_ff[1];
   assign rsp_ch.blue        = rsp_chan_ff[2];
   assign rsp_ch.strip_level = rsp_level_ff;
   assign rsp_ch.last_pixel  = rsp_last_ff;

   assign status.frame_go = frame_go;
   assign status.raw      = raw_in;
   assign status.dim      = dim_ff;
   assign status.last     = last;
   assign status.out_free = !rsp_valid_ff || rsp_ch.ready;

endmodule

// File: hdl/led_strip_effect_generator_unit.sv
// LED strip effect generator. Commands arrive on req_ch (tick, start accent, render now);
// a tick that does not complete a frame interval, an accent start and an unknown command
// emit no pixels and leave the unit ready. A tick that completes the interval, and every
// render command, emit LED_COUNT pixel transactions on rsp_ch, pixel 0 first, last_pixel
// set on the final one. Each pixel runs through one shared three-channel multiply and
// divide-by-100 unit in steps: percent, scale, dim (dimmed sleepy-drift pixels only), boost,
// output; spark flash pixels go from percent to output. Output waits while the output register
// holds a pixel that rsp_ch.ready has not taken. A new command is taken once the last pixel of
// the frame sits in the output register. Register writes on csr_ch are always ready and
// belong between frames; strip_level follows a brightness write via lvl_prod_ff and level_ff.
module led_strip_effect_generator_unit #(
   parameter int LED_COUNT = led_fx_pkg::LED_COUNT_DEF
) (
   input  logic          clock,
   input  logic          reset,
   led_fx_req_if.sink    req_ch,
   led_fx_rsp_if.source  rsp_ch,
   led_fx_csr_if.sink    csr_ch
);
   import led_fx_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   led_fx_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   led_fx_dp #(
      .LED_COUNT (LED_COUNT)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch),
      .cmd    (cmd),
      .status (status)
   );

endmodule

// File: hdl/led_fx_checker.sv
module led_fx_checker #(
   parameter int LED_COUNT = led_fx_pkg::LED_COUNT_DEF
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [led_fx_pkg::PIX_IDX_W-1:0] rsp_pixel_index,
   input logic [led_fx_pkg::CHAN_W-1:0]    rsp_red,
   input logic [led_fx_pkg::CHAN_W-1:0]    rsp_green,
   input logic [led_fx_pkg::CHAN_W-1:0]    rsp_blue,
   input logic [led_fx_pkg::CHAN_W-1:0]    rsp_strip_level,
   input logic                             rsp_last_pixel
);
   import led_fx_pkg::*;

   localparam logic [PIX_IDX_W:0]   PIX_LIMIT = (PIX_IDX_W+1)'(LED_COUNT);
   localparam logic [PIX_IDX_W-1:0] PIX_LAST  = PIX_IDX_W'(LED_COUNT - 1);

   // a stalled transaction keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_pixel_index, rsp_red, rsp_green, rsp_blue, rsp_strip_level,
                  rsp_last_pixel}))
      else $error("rsp payload changed while stalled");

   // no command taken in the middle of a frame
   a_busy_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_pixel |-> !req_ready)
      else $error("command taken while a frame is in progress");

   // pixel index stays on the strip and marks the final pixel
   a_pixel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_pixel_index} < PIX_LIMIT) &&
         (rsp_last_pixel == (rsp_pixel_index == PIX_LAST)))
      else $error("pixel index and last flag disagree");

endmodule

bind led_strip_effect_generator_unit led_fx_checker #(
   .LED_COUNT (LED_COUNT)
) u_led_fx_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_pixel_index (rsp_ch.pixel_index),
   .rsp_red         (rsp_ch.red),
   .rsp_green       (rsp_ch.green),
   .rsp_blue        (rsp_ch.blue),
   .rsp_strip_level (rsp_ch.strip_level),
   .rsp_last_pixel  (rsp_ch.last_pixel)
);
